@@ rtl/chs_pkg.sv @@
`timescale 1ns / 1ps
package chs_pkg;

    localparam int BINS       = 64;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 20;
    localparam int PROB_BITS  = 32;
    localparam int OUT_W      = 24;
    localparam int IDX_IN_W   = 6;

    localparam int BIN_W   = $clog2(BINS);
    localparam int WORD_W  = 2 * COUNT_BITS;
    localparam int P_W     = PROB_BITS + 1;
    localparam int S_W     = P_W + 1;
    localparam int U_W     = FRAC_BITS + 2;
    localparam int PROD_W  = U_W + P_W;
    localparam int TERM_W  = PROD_W - PROB_BITS;
    localparam int NUM_P_W = COUNT_BITS + PROB_BITS;
    localparam int NUM_U_W = P_W + FRAC_BITS + 1;
    localparam int DIV_NW  = (NUM_P_W > NUM_U_W) ? NUM_P_W : NUM_U_W;
    localparam int DIV_DW  = S_W;
    localparam int DIV_CNT_W = $clog2(DIV_NW + 1);
    localparam int SUM_RAW = FRAC_BITS + 3 + BIN_W;
    localparam int SUM_W   = (SUM_RAW > OUT_W + 1) ? SUM_RAW : OUT_W + 1;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    typedef struct packed {
        logic                sample_select;
        logic [IDX_IN_W-1:0] record_depth;
        logic [IDX_IN_W-1:0] record_children;
        logic                last_record;
    } record_t;

    typedef struct packed {
        logic [OUT_W-1:0] distance_total;
        logic [OUT_W-1:0] depth_part;
        logic [OUT_W-1:0] degree_part;
        logic [1:0]       result_status;
    } result_t;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_UPDATE,
        S_RD,
        S_LAT,
        S_CHECK,
        S_DIVP,
        S_DIVQ,
        S_DS,
        S_STARTU,
        S_DIVU,
        S_MUL,
        S_ACC,
        S_NEXT,
        S_FIN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_P,
        DIV_Q,
        DIV_U
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    update;
        logic    latch;
        logic    div_start;
        div_op_t div_op;
        logic    calc_ds;
        logic    mul;
        logic    acc;
        logic    part_next;
        logic    clr_write;
        logic    bin_inc;
        logic    finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic part_last;
        logic bin_last;
        logic rec_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [BIN_W-1:0] clamp_bin(input logic [IDX_IN_W-1:0] v);
        if (int'(v) >= BINS) begin
            return BIN_W'(BINS - 1);
        end
        return BIN_W'(v);
    endfunction

endpackage

@@ rtl/chs_div.sv @@
`timescale 1ns / 1ps
module chs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [chs_pkg::DIV_NW-1:0] num,
    input  logic [chs_pkg::DIV_DW-1:0] den,
    output logic                      done,
    output logic [chs_pkg::P_W-1:0]   quo
);
    import chs_pkg::*;

    logic [DIV_NW-1:0]    num_reg;
    logic [DIV_DW-1:0]    den_reg;
    logic [DIV_DW-1:0]    rem_reg;
    logic [DIV_NW-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DW:0]      trial;
    logic [DIV_DW:0]      diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[DIV_NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg[P_W-1:0];

endmodule

@@ rtl/chs_datapath.sv @@
`timescale 1ns / 1ps
module chs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  chs_pkg::record_t    record,
    input  chs_pkg::ctrl_cmd_t  cmd,
    input  logic                result_stall,
    output chs_pkg::dp_status_t dp_stat,
    output logic                result_valid,
    output chs_pkg::result_t    result
);
    import chs_pkg::*;

    logic [WORD_W-1:0] depth_mem  [BINS];
    logic [WORD_W-1:0] degree_mem [BINS];
    logic [WORD_W-1:0] depth_rd_reg;
    logic [WORD_W-1:0] degree_rd_reg;
    logic [BIN_W-1:0]  depth_rd_addr;
    logic [BIN_W-1:0]  degree_rd_addr;
    logic              depth_wr_en;
    logic              degree_wr_en;
    logic [BIN_W-1:0]  depth_wr_addr;
    logic [BIN_W-1:0]  degree_wr_addr;
    logic [WORD_W-1:0] depth_wr_data;
    logic [WORD_W-1:0] degree_wr_data;

    logic              sel_reg;
    logic [BIN_W-1:0]  dep_idx_reg;
    logic [BIN_W-1:0]  chi_idx_reg;
    logic              last_reg;
    logic              drop_reg;
    logic              drop;

    logic [COUNT_BITS-1:0] cnt_first_reg;
    logic [COUNT_BITS-1:0] cnt_second_reg;
    logic                  ovf_reg;

    logic [COUNT_BITS-1:0] a0_reg;
    logic [COUNT_BITS-1:0] b0_reg;
    logic [COUNT_BITS-1:0] a1_reg;
    logic [COUNT_BITS-1:0] b1_reg;
    logic [COUNT_BITS-1:0] cur_a;
    logic [COUNT_BITS-1:0] cur_b;
    logic                  part_reg;
    logic [BIN_W-1:0]      bin_reg;
    logic                  bin_last;
    logic                  empty;

    logic [P_W-1:0]    p_reg;
    logic [P_W-1:0]    q_reg;
    logic [P_W-1:0]    d_reg;
    logic [S_W-1:0]    s_reg;
    logic [U_W-1:0]    u_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TERM_W-1:0] term;
    logic [SUM_W-1:0]  acc0_reg;
    logic [SUM_W-1:0]  acc1_reg;
    div_op_t           div_op_reg;

    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_done;
    logic [P_W-1:0]    div_quo;

    logic              dp_sat;
    logic              gp_sat;
    logic              tot_sat;
    logic [OUT_W-1:0]  dp_val;
    logic [OUT_W-1:0]  gp_val;
    logic [OUT_W:0]    tot_raw;
    logic [OUT_W-1:0]  tot_val;
    logic [1:0]        code;

    result_t           result_reg;
    logic              result_valid_reg;

    chs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign depth_rd_addr  = cmd.load ? clamp_bin(record.record_depth) : bin_reg;
    assign degree_rd_addr = cmd.load ? clamp_bin(record.record_children) : bin_reg;

    assign depth_wr_en    = (cmd.update && !drop_reg) || cmd.clr_write;
    assign degree_wr_en   = depth_wr_en;
    assign depth_wr_addr  = cmd.clr_write ? bin_reg : dep_idx_reg;
    assign degree_wr_addr = cmd.clr_write ? bin_reg : chi_idx_reg;

    always_comb
    begin
        if (cmd.clr_write)
        begin
            depth_wr_data  = '0;
            degree_wr_data = '0;
        end
        else if (sel_reg)
        begin
            depth_wr_data  = {depth_rd_reg[WORD_W-1:COUNT_BITS] + COUNT_BITS'(1),
                              depth_rd_reg[COUNT_BITS-1:0]};
            degree_wr_data = {degree_rd_reg[WORD_W-1:COUNT_BITS] + COUNT_BITS'(1),
                              degree_rd_reg[COUNT_BITS-1:0]};
        end
        else
        begin
            depth_wr_data  = {depth_rd_reg[WORD_W-1:COUNT_BITS],
                              depth_rd_reg[COUNT_BITS-1:0] + COUNT_BITS'(1)};
            degree_wr_data = {degree_rd_reg[WORD_W-1:COUNT_BITS],
                              degree_rd_reg[COUNT_BITS-1:0] + COUNT_BITS'(1)};
        end
    end

    always_ff @(posedge clk)
    begin
        depth_rd_reg  <= depth_mem[depth_rd_addr];
        degree_rd_reg <= degree_mem[degree_rd_addr];
        if (depth_wr_en)
        begin
            depth_mem[depth_wr_addr] <= depth_wr_data;
        end
        if (degree_wr_en)
        begin
            degree_mem[degree_wr_addr] <= degree_wr_data;
        end
    end

    assign drop     = record.sample_select ? (&cnt_second_reg) : (&cnt_first_reg);
    assign cur_a    = part_reg ? a1_reg : a0_reg;
    assign cur_b    = part_reg ? b1_reg : b0_reg;
    assign empty    = (cnt_first_reg == '0) || (cnt_second_reg == '0);
    assign bin_last = bin_reg == BIN_W'(BINS - 1);
    assign term     = prod_reg[PROD_W-1:PROB_BITS];

    always_comb
    begin
        unique case (cmd.div_op)
            DIV_P:
            begin
                div_num = DIV_NW'({cur_a, {PROB_BITS{1'b0}}});
                div_den = DIV_DW'(cnt_first_reg);
            end
            DIV_Q:
            begin
                div_num = DIV_NW'({cur_b, {PROB_BITS{1'b0}}});
                div_den = DIV_DW'(cnt_second_reg);
            end
            DIV_U:
            begin
                div_num = DIV_NW'({d_reg, {(FRAC_BITS + 1){1'b0}}});
                div_den = s_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_first_reg  <= '0;
            cnt_second_reg <= '0;
            ovf_reg        <= 1'b0;
            acc0_reg       <= '0;
            acc1_reg       <= '0;
            part_reg       <= 1'b0;
            bin_reg        <= '0;
            last_reg       <= 1'b0;
            drop_reg       <= 1'b0;
            div_op_reg     <= DIV_P;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg <= record.last_record;
                drop_reg <= drop;
                if (drop)
                begin
                    ovf_reg <= 1'b1;
                end
                else if (record.sample_select)
                begin
                    cnt_second_reg <= cnt_second_reg + COUNT_BITS'(1);
                end
                else
                begin
                    cnt_first_reg <= cnt_first_reg + COUNT_BITS'(1);
                end
            end
            if (cmd.div_start)
            begin
                div_op_reg <= cmd.div_op;
            end
            if (cmd.latch)
            begin
                part_reg <= 1'b0;
            end
            else if (cmd.part_next)
            begin
                part_reg <= 1'b1;
            end
            if (cmd.bin_inc)
            begin
                bin_reg <= bin_last ? '0 : bin_reg + BIN_W'(1);
            end
            if (cmd.acc)
            begin
                if (part_reg)
                begin
                    acc1_reg <= acc1_reg + SUM_W'(term);
                end
                else
                begin
                    acc0_reg <= acc0_reg + SUM_W'(term);
                end
            end
            if (cmd.finish)
            begin
                cnt_first_reg  <= '0;
                cnt_second_reg <= '0;
                ovf_reg        <= 1'b0;
                acc0_reg       <= '0;
                acc1_reg       <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sel_reg     <= record.sample_select;
            dep_idx_reg <= clamp_bin(record.record_depth);
            chi_idx_reg <= clamp_bin(record.record_children);
        end
        if (cmd.latch)
        begin
            a0_reg <= depth_rd_reg[COUNT_BITS-1:0];
            b0_reg <= depth_rd_reg[WORD_W-1:COUNT_BITS];
            a1_reg <= degree_rd_reg[COUNT_BITS-1:0];
            b1_reg <= degree_rd_reg[WORD_W-1:COUNT_BITS];
        end
        if (div_done)
        begin
            unique case (div_op_reg)
                DIV_P:   p_reg <= div_quo;
                DIV_Q:   q_reg <= div_quo;
                DIV_U:   u_reg <= div_quo[U_W-1:0];
                default: u_reg <= u_reg;
            endcase
        end
        if (cmd.calc_ds)
        begin
            d_reg <= (p_reg > q_reg) ? p_reg - q_reg : q_reg - p_reg;
            s_reg <= {1'b0, p_reg} + {1'b0, q_reg};
        end
        if (cmd.mul)
        begin
            prod_reg <= u_reg * d_reg;
        end
    end

    assign dp_sat  = acc0_reg > SUM_W'(OUT_MAX);
    assign gp_sat  = acc1_reg > SUM_W'(OUT_MAX);
    assign dp_val  = dp_sat ? OUT_MAX : acc0_reg[OUT_W-1:0];
    assign gp_val  = gp_sat ? OUT_MAX : acc1_reg[OUT_W-1:0];
    assign tot_raw = {1'b0, dp_val} + {1'b0, gp_val};
    assign tot_sat = tot_raw[OUT_W];
    assign tot_val = tot_sat ? OUT_MAX : tot_raw[OUT_W-1:0];

    always_comb
    begin
        if (empty)
        begin
            code = STATUS_EMPTY;
        end
        else if (dp_sat || gp_sat || tot_sat || ovf_reg)
        begin
            code = STATUS_SAT;
        end
        else
        begin
            code = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.distance_total <= empty ? '0 : tot_val;
            result_reg.depth_part     <= empty ? '0 : dp_val;
            result_reg.degree_part    <= empty ? '0 : gp_val;
            result_reg.result_status  <= code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign dp_stat.skip      = empty || ((cur_a == '0) && (cur_b == '0));
    assign dp_stat.div_done  = div_done;
    assign dp_stat.part_last = part_reg;
    assign dp_stat.bin_last  = bin_last;
    assign dp_stat.rec_last  = last_reg;
    assign dp_stat.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/chs_ctrl.sv @@
`timescale 1ns / 1ps
module chs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                record_valid,
    input  chs_pkg::dp_status_t dp_stat,
    output chs_pkg::ctrl_cmd_t  cmd,
    output logic                record_stall
);
    import chs_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_P;
        unique case (state_reg)
            S_INIT_CLR:
            begin
                cmd.clr_write = 1'b1;
                cmd.bin_inc   = 1'b1;
                if (dp_stat.bin_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (record_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = dp_stat.rec_last ? S_RD : S_IDLE;
            end
            S_RD:
            begin
                state_next = S_LAT;
            end
            S_LAT:
            begin
                cmd.latch  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (dp_stat.skip)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_P;
                    state_next    = S_DIVP;
                end
            end
            S_DIVP:
            begin
                if (dp_stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_Q;
                    state_next    = S_DIVQ;
                end
            end
            S_DIVQ:
            begin
                if (dp_stat.div_done)
                begin
                    state_next = S_DS;
                end
            end
            S_DS:
            begin
                cmd.calc_ds = 1'b1;
                state_next  = S_STARTU;
            end
            S_STARTU:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_U;
                state_next    = S_DIVU;
            end
            S_DIVU:
            begin
                if (dp_stat.div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (dp_stat.part_last)
                begin
                    cmd.clr_write = 1'b1;
                    cmd.bin_inc   = 1'b1;
                    state_next    = dp_stat.bin_last ? S_FIN : S_RD;
                end
                else
                begin
                    cmd.part_next = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_FIN:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign record_stall = state_reg != S_IDLE;

endmodule

@@ rtl/chi_square_histogram_distance.sv @@
`timescale 1ns / 1ps
// Chi-square distance between the depth and child count histograms of two samples.
// Record channel: record_valid / record_stall with a record_t item. Each item adds
// one to its sample's depth bin, degree bin and record counter, unless that counter
// is full (the item is then dropped and flags saturation). The block reads, then
// writes back, the bin memories for each record while it holds record_stall high.
// An item with last_record set starts the bin walk after its write-back. Each bin
// is read, then each of its two histogram pairs is checked; a pair that is empty in
// both samples, or any pair while a sample has no records, is skipped. A pair that
// is not skipped runs three divisions on a shared one-bit-per-cycle divider, then
// a multiply and an accumulate; after the last bin the result register is loaded.
// The walk clears each bin after reading it.
// Result channel: result_valid / result_stall with a result_t item held in an
// output register until taken; while the receiver stalls a finished walk waits
// and the record side stays stalled.
// Reset: the bin memories are cleared by a sweep over all BINS bins after rst_n
// releases, with record_stall high; counters and flags clear at once.
module chi_square_histogram_distance (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              record_valid,
    output logic              record_stall,
    input  chs_pkg::record_t  record,
    output logic              result_valid,
    input  logic              result_stall,
    output chs_pkg::result_t  result
);
    import chs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    chs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .record_valid (record_valid),
        .dp_stat      (dp_stat),
        .cmd          (cmd),
        .record_stall (record_stall)
    );

    chs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .record       (record),
        .cmd          (cmd),
        .result_stall (result_stall),
        .dp_stat      (dp_stat),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_busy_after_record: assert property (@(posedge clk) disable iff (!rst_n)
        (record_valid && !record_stall) |=> record_stall)
        else $error("record accepted on consecutive cycles");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_status == STATUS_EMPTY) |->
        (result.distance_total == '0 && result.depth_part == '0))
        else $error("empty sample result carries a value");

    a_total_covers_parts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.distance_total >= result.depth_part &&
                          result.distance_total >= result.degree_part))
        else $error("total below one of its parts");
`endif

endmodule
